// File: design/lpfs_pkg.sv
// Package for the LED panel frame store and scanner.
// Holds geometry constants, opcodes, FSM states and the request and result structs.
// No dependencies.
package lpfs_pkg;

	localparam int COLUMNS   = 32;
	localparam int HALF_ROWS = 8;
	localparam int DEPTH     = COLUMNS * HALF_ROWS;
	localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COL_W     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int HROW_W    = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
	localparam int YROW_W    = $clog2(2 * HALF_ROWS);
	localparam int ROW_W     = 3;
	localparam int RGB_W     = 3;
	localparam int ENTRY_W   = 2 * RGB_W;

	typedef enum logic [1:0] {
		OP_PIXEL   = 2'd0,
		OP_FILL    = 2'd1,
		OP_PRESENT = 2'd2,
		OP_SCAN    = 2'd3
	} op_t;

	localparam logic KIND_SHIFT = 1'b0;
	localparam logic KIND_LATCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COPY,
		ST_SHIFT,
		ST_LATCH
	} state_t;

	typedef struct packed {
		logic              vld;
		logic [ADDR_W-1:0] addr;
		logic              half;
		logic [RGB_W-1:0]  color;
	} pix_req_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} rd_req_t;

	typedef struct packed {
		logic               en;
		logic [ADDR_W-1:0]  addr;
		logic [ENTRY_W-1:0] data;
	} wr_req_t;

	typedef struct packed {
		logic             strobe;
		logic             kind;
		logic [RGB_W-1:0] top_rgb;
		logic [RGB_W-1:0] bottom_rgb;
		logic [ROW_W-1:0] row_address;
		logic             frame_end;
		logic             last;
	} res_t;

endpackage

// File: design/led_panel_framebuffer_scan.sv
// Top level of the double-buffered LED panel frame store and row scanner.
// Instantiates lpfs_draw_store, lpfs_show_store and lpfs_scan_ctrl; uses lpfs_pkg.
//
// channel   direction  handshake               payload
// command   in         start & !busy           opcode, pos_x, pos_y, color
// result    out        strobe, one cycle each  kind, top_rgb, bottom_rgb,
//                                              row_address, frame_end, last
//
// Pixel write and fill: a new word every cycle, busy stays low.
// Present: busy while the DEPTH entries are copied, one entry per cycle over the draw RAM port.
// Scan: busy while the row is shifted out and latched; results pass the state, display
// RAM read and result registers and come one per cycle, paced by the display RAM read port.
// Reset leaves both stores black and the row counter at zero; no clearing pass.
// Results cannot be stalled; the strobe marks each one for a single cycle.
module led_panel_framebuffer_scan (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        opcode,
	input  logic signed [15:0]                pos_x,
	input  logic signed [15:0]                pos_y,
	input  logic [lpfs_pkg::RGB_W-1:0]        color,
	output logic                              strobe,
	output logic                              kind,
	output logic [lpfs_pkg::RGB_W-1:0]        top_rgb,
	output logic [lpfs_pkg::RGB_W-1:0]        bottom_rgb,
	output logic [lpfs_pkg::ROW_W-1:0]        row_address,
	output logic                              frame_end,
	output logic                              last
);
	import lpfs_pkg::*;

	logic               accept;
	op_t                op;
	logic               on_panel;
	logic [YROW_W-1:0]  y_lo;
	logic               half;
	logic [HROW_W-1:0]  y_row;
	pix_req_t           pix;
	rd_req_t            draw_rd;
	rd_req_t            show_rd;
	wr_req_t            show_wr;
	logic [ENTRY_W-1:0] draw_data;
	logic [ENTRY_W-1:0] show_data;
	res_t               res;

	assign accept = start && !busy;
	assign op     = op_t'(opcode);

	assign on_panel = !pos_x[15] && (pos_x < 16'(COLUMNS))
	                  && !pos_y[15] && (pos_y < 16'(2 * HALF_ROWS));
	assign y_lo  = pos_y[YROW_W-1:0];
	assign half  = ({1'b0, y_lo} >= (YROW_W + 1)'(HALF_ROWS));
	assign y_row = half ? HROW_W'(y_lo - YROW_W'(HALF_ROWS)) : HROW_W'(y_lo);

	always_comb begin
		pix.vld   = accept && op == OP_PIXEL && on_panel;
		pix.addr  = ADDR_W'(y_row) * ADDR_W'(COLUMNS) + ADDR_W'(pos_x[COL_W-1:0]);
		pix.half  = half;
		pix.color = color;
	end

	lpfs_draw_store u_draw (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix),
		.fill_en    (accept && op == OP_FILL),
		.fill_color (color),
		.sweep      (draw_rd),
		.sweep_data (draw_data)
	);

	lpfs_show_store u_show (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (show_wr),
		.rd     (show_rd),
		.data   (show_data)
	);

	lpfs_scan_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.op        (op),
		.busy      (busy),
		.draw_rd   (draw_rd),
		.draw_data (draw_data),
		.show_wr   (show_wr),
		.show_rd   (show_rd),
		.show_data (show_data),
		.res       (res)
	);

	assign strobe      = res.strobe;
	assign kind        = res.kind;
	assign top_rgb     = res.top_rgb;
	assign bottom_rgb  = res.bottom_rgb;
	assign row_address = res.row_address;
	assign frame_end   = res.frame_end;
	assign last        = res.last;

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("result right after a row latch");

	a_shift_clean: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_SHIFT |-> !last && !frame_end && row_address == '0)
		else $error("shift word carries latch fields");

	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && frame_end |-> kind == KIND_LATCH && row_address == ROW_W'(HALF_ROWS - 1))
		else $error("frame end on wrong row");

endmodule

// File: design/lpfs_draw_store.sv
// Drawing store: synchronous RAM with per-entry valid bits and a fill color.
// Pixel writes read, merge and write back with forwarding of the last write.
// Depends on lpfs_pkg.
module lpfs_draw_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lpfs_pkg::pix_req_t         pix,
	input  logic                       fill_en,
	input  logic [lpfs_pkg::RGB_W-1:0] fill_color,
	input  lpfs_pkg::rd_req_t          sweep,
	output logic [lpfs_pkg::ENTRY_W-1:0] sweep_data
);
	import lpfs_pkg::*;

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]   vld_q;
	logic [RGB_W-1:0]   fill_q;
	logic [ENTRY_W-1:0] rdata_s1;
	pix_req_t           pix_s1;
	logic [ADDR_W-1:0]  sweep_addr_s1;
	logic               fwd_vld_q;
	logic [ADDR_W-1:0]  fwd_addr_q;
	logic [ENTRY_W-1:0] fwd_data_q;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ENTRY_W-1:0] base;
	logic [ENTRY_W-1:0] merged;

	assign rd_addr = sweep.en ? sweep.addr : pix.addr;

	always_ff @(posedge clk) begin
		rdata_s1 <= mem[rd_addr];
		sweep_addr_s1 <= sweep.addr;
		if (pix_s1.vld) begin
			mem[pix_s1.addr] <= merged;
		end
		fwd_addr_q <= pix_s1.addr;
		fwd_data_q <= merged;
	end

	always_comb begin
		if (fwd_vld_q && fwd_addr_q == pix_s1.addr) begin
			base = fwd_data_q;
		end else if (vld_q[pix_s1.addr]) begin
			base = rdata_s1;
		end else begin
			base = {fill_q, fill_q};
		end
		if (pix_s1.half) begin
			merged = {pix_s1.color, base[RGB_W-1:0]};
		end else begin
			merged = {base[ENTRY_W-1:RGB_W], pix_s1.color};
		end
	end

	assign sweep_data = vld_q[sweep_addr_s1] ? rdata_s1 : {fill_q, fill_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			fill_q    <= '0;
			pix_s1    <= '0;
			fwd_vld_q <= 1'b0;
		end else begin
			pix_s1    <= pix;
			fwd_vld_q <= pix_s1.vld && !fill_en;
			if (fill_en) begin
				vld_q  <= '0;
				fill_q <= fill_color;
			end else if (pix_s1.vld) begin
				vld_q[pix_s1.addr] <= 1'b1;
			end
		end
	end

endmodule

// File: design/lpfs_show_store.sv
// Display store: synchronous RAM written by the copy sweep, read by the scan.
// Reads as black until the first copy lands. Depends on lpfs_pkg.
module lpfs_show_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lpfs_pkg::wr_req_t            wr,
	input  lpfs_pkg::rd_req_t            rd,
	output logic [lpfs_pkg::ENTRY_W-1:0] data
);
	import lpfs_pkg::*;

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rdata_s1;
	logic               loaded_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rdata_s1 <= mem[rd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
		end else if (wr.en) begin
			loaded_q <= 1'b1;
		end
	end

	assign data = loaded_q ? rdata_s1 : '0;

endmodule

// File: design/lpfs_scan_ctrl.sv
// Sequencer for the present copy sweep and the row scan, with result register.
// Drives the read ports of both stores and the display store write port.
// Depends on lpfs_pkg.
module lpfs_scan_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  lpfs_pkg::op_t                op,
	output logic                         busy,
	output lpfs_pkg::rd_req_t            draw_rd,
	input  logic [lpfs_pkg::ENTRY_W-1:0] draw_data,
	output lpfs_pkg::wr_req_t            show_wr,
	output lpfs_pkg::rd_req_t            show_rd,
	input  logic [lpfs_pkg::ENTRY_W-1:0] show_data,
	output lpfs_pkg::res_t               res
);
	import lpfs_pkg::*;

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [ROW_W-1:0]  scan_row_q, scan_row_d;
	logic              lat_d;
	logic              copy_s1;
	logic [ADDR_W-1:0] copy_addr_s1;
	logic              shift_s1;
	logic              lat_s1;
	logic [ROW_W-1:0]  lat_row_s1;
	res_t              res_q;

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		col_d      = col_q;
		row_d      = row_q;
		scan_row_d = scan_row_q;
		lat_d      = 1'b0;
		draw_rd    = '0;
		show_rd    = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_PRESENT) begin
					cnt_d   = '0;
					state_d = ST_COPY;
				end else if (accept && op == OP_SCAN) begin
					row_d   = ({1'b0, scan_row_q} < 4'(HALF_ROWS)) ? scan_row_q : '0;
					col_d   = '0;
					state_d = ST_SHIFT;
				end
			end
			ST_COPY: begin
				draw_rd.en   = 1'b1;
				draw_rd.addr = cnt_q;
				if (cnt_q == ADDR_W'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_SHIFT: begin
				show_rd.en   = 1'b1;
				show_rd.addr = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
				if (col_q == COL_W'(COLUMNS - 1)) begin
					state_d = ST_LATCH;
				end else begin
					col_d = col_q + 1'b1;
				end
			end
			ST_LATCH: begin
				lat_d      = 1'b1;
				scan_row_d = (row_q == ROW_W'(HALF_ROWS - 1)) ? '0 : row_q + 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			col_q      <= '0;
			row_q      <= '0;
			scan_row_q <= '0;
			copy_s1    <= 1'b0;
			shift_s1   <= 1'b0;
			lat_s1     <= 1'b0;
			res_q      <= '0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			col_q      <= col_d;
			row_q      <= row_d;
			scan_row_q <= scan_row_d;
			copy_s1    <= draw_rd.en;
			shift_s1   <= show_rd.en;
			lat_s1     <= lat_d;
			if (shift_s1) begin
				res_q <= '{strobe: 1'b1, kind: KIND_SHIFT,
					top_rgb: show_data[RGB_W-1:0],
					bottom_rgb: show_data[ENTRY_W-1:RGB_W],
					row_address: '0, frame_end: 1'b0, last: 1'b0};
			end else if (lat_s1) begin
				res_q <= '{strobe: 1'b1, kind: KIND_LATCH,
					top_rgb: '0, bottom_rgb: '0,
					row_address: lat_row_s1,
					frame_end: (lat_row_s1 == ROW_W'(HALF_ROWS - 1)),
					last: 1'b1};
			end else begin
				res_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		copy_addr_s1 <= draw_rd.addr;
		lat_row_s1   <= row_q;
	end

	assign busy    = (state_q != ST_IDLE);
	assign show_wr = '{en: copy_s1, addr: copy_addr_s1, data: draw_data};
	assign res     = res_q;

endmodule
